// File: design/dam_pkg.sv
// Shared types and constants of the decimal accumulator machine.
// Used by dam_muldiv and decimal_accumulator_machine_unit; depends on nothing.
`default_nettype none

package dam_pkg;

  // Machine geometry
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned MEM_WORDS = 100;
  localparam int unsigned ADDR_W    = 7;
  localparam int unsigned OPC_W     = 6;
  localparam int unsigned CNT_W     = 5;

  // Decimal decoding: opcode = word / 100, only words 1000..4399 carry a known opcode
  localparam int unsigned DEC_BASE    = 100;
  localparam int unsigned DEC_W       = 13;
  localparam int unsigned WORD_LOW    = 1000;
  localparam int unsigned WORD_HIGH   = 4400;
  localparam int unsigned RECIP_100   = 2622;
  localparam int unsigned RECIP_SHIFT = 18;
  localparam int unsigned RECIP_W     = 12;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_EXEC    = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

  typedef enum logic [OPC_W-1:0] {
    OP_READ       = 6'd10,
    OP_WRITE      = 6'd11,
    OP_LOAD       = 6'd20,
    OP_STORE      = 6'd21,
    OP_ADD        = 6'd30,
    OP_SUB        = 6'd31,
    OP_DIV        = 6'd32,
    OP_MUL        = 6'd33,
    OP_BRANCH     = 6'd40,
    OP_BRANCHNEG  = 6'd41,
    OP_BRANCHZERO = 6'd42,
    OP_HALT       = 6'd43
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_ADDR,
    ST_OPER,
    ST_ITER,
    ST_RESP
  } state_e;

  // Request to and response from the iterative multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } md_rsp_t;

endpackage

`default_nettype wire

// File: design/dam_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module dam_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 100
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/dam_muldiv.sv
// Iterative 32-bit multiply (low word) and signed truncating divide, one bit per cycle.
// Depends on dam_pkg for widths and the request/response structs.
`default_nettype none

module dam_muldiv import dam_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire md_req_t           req_i,
  input  wire logic [WORD_W-1:0] a_i,
  input  wire logic [WORD_W-1:0] b_i,
  output md_rsp_t                rsp_o
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  logic              busy_q, done_q, is_div_q, neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WORD_W-1:0] rem_q, quo_q, div_q;

  logic [WORD_W:0]   shin, add_x, add_y, sum;
  logic [WORD_W-1:0] a_mag, b_mag, quo_signed;

  // Shared adder: subtract for a divide step, add for a multiply step
  always_comb begin
    shin  = {rem_q, quo_q[WORD_W-1]};
    add_x = is_div_q ? shin : {1'b0, rem_q};
    add_y = {1'b0, div_q} ^ {(WORD_W+1){is_div_q}};
    sum   = add_x + add_y + (WORD_W+1)'(is_div_q);
  end

  // Operand magnitudes for the divide
  assign a_mag      = a_i[WORD_W-1] ? (~a_i + WORD_W'(1)) : a_i;
  assign b_mag      = b_i[WORD_W-1] ? (~b_i + WORD_W'(1)) : b_i;
  assign quo_signed = neg_q ? (~quo_q + WORD_W'(1)) : quo_q;

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then one bit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      is_div_q <= req_i.is_div;
      rem_q    <= '0;
      if (req_i.is_div) begin
        quo_q <= a_mag;
        div_q <= b_mag;
        neg_q <= a_i[WORD_W-1] ^ b_i[WORD_W-1];
      end else begin
        quo_q <= b_i;
        div_q <= a_i;
        neg_q <= 1'b0;
      end
    end else if (busy_q) begin
      if (is_div_q) begin
        if (!sum[WORD_W]) begin
          rem_q <= sum[WORD_W-1:0];
          quo_q <= {quo_q[WORD_W-2:0], 1'b1};
        end else begin
          rem_q <= shin[WORD_W-1:0];
          quo_q <= {quo_q[WORD_W-2:0], 1'b0};
        end
      end else begin
        if (quo_q[0]) begin
          rem_q <= sum[WORD_W-1:0];
        end
        quo_q <= {1'b0, quo_q[WORD_W-1:1]};
        div_q <= {div_q[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = is_div_q ? quo_signed : rem_q;

endmodule

`default_nettype wire

// File: design/decimal_accumulator_machine_unit.sv
// Decimal accumulator machine: top level with sequencer, word store and accumulator.
// Depends on dam_pkg, dam_ram and dam_muldiv.
//
// One item is one step: mode 0 writes a word of the 100-word store, mode 1 executes the
// instruction at the program counter, mode 2 restarts pc and accumulator. Every item
// gives exactly one result item. A load, restart, or an execute while halted goes from idle
// straight to the response state; an executed instruction walks fetch, decode, address and
// operand stages, then MUL, and DIV with a nonzero divisor, run in the shared bit-serial
// multiply/divide unit. Input is taken only when the sequencer is idle; the result
// sits in an output register, so the next item can enter while it waits to be taken. The
// store is cleared at reset through per-word valid bits, so no clearing pass is needed.
`default_nettype none

module decimal_accumulator_machine_unit import dam_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [ADDR_W-1:0] load_address_i,
  input  wire logic [WORD_W-1:0] load_value_i,
  input  wire logic [WORD_W-1:0] read_value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   write_valid_o,
  output logic [WORD_W-1:0]      write_value_o,
  output logic                   read_used_o,
  output logic                   halted_o,
  output logic                   divide_fault_o,
  output logic [ADDR_W-1:0]      program_counter_o,
  output logic [WORD_W-1:0]      accumulator_out_o
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_WORDS - 1);
  localparam logic [ADDR_W-1:0] END_ADDR  = ADDR_W'(MEM_WORDS);

  state_e state_q, state_d;

  logic                    accept, out_free;
  logic                    stopped_q;
  logic [ADDR_W-1:0]       pc_q;
  logic [WORD_W-1:0]       acc_q;
  logic [WORD_W-1:0]       read_value_q;
  logic                    wv_q, ru_q, df_q;
  logic [WORD_W-1:0]       wval_q;
  logic [MEM_WORDS-1:0]    valid_q;
  logic                    rd_vld_q;

  logic [OPC_W-1:0]        op_q;
  logic [DEC_W-1:0]        dec_q;
  logic                    known_q;
  logic [ADDR_W-1:0]       ad_q;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [WORD_W-1:0]       ram_wdata, ram_rdata, rd_word;

  logic [DEC_W+RECIP_W-1:0] recip_prod;
  logic                     word_known;
  logic [DEC_W-1:0]         ad_full;
  opcode_e                  opc;
  logic [ADDR_W-1:0]        pc_inc;
  logic [ADDR_W-1:0]        pc_next;
  logic                     taken;

  md_req_t md_req;
  md_rsp_t md_rsp;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_o || out_ready_i;
  assign rd_word  = rd_vld_q ? ram_rdata : '0;

  // Decode: opcode by reciprocal multiply, only for words with a known opcode range
  assign recip_prod = (DEC_W+RECIP_W)'(rd_word[DEC_W-1:0]) *
                      (DEC_W+RECIP_W)'(RECIP_100);
  assign word_known = !rd_word[WORD_W-1] && (rd_word[WORD_W-2:DEC_W] == '0) &&
                      (rd_word[DEC_W-1:0] >= DEC_W'(WORD_LOW)) &&
                      (rd_word[DEC_W-1:0] <  DEC_W'(WORD_HIGH));
  assign ad_full    = dec_q - (DEC_W'(op_q) * DEC_W'(DEC_BASE));
  assign opc        = opcode_e'(op_q);

  // Branch decision and next program counter
  always_comb begin
    taken = 1'b0;
    if (known_q) begin
      case (opc)
        OP_BRANCH:     taken = 1'b1;
        OP_BRANCHNEG:  taken = acc_q[WORD_W-1];
        OP_BRANCHZERO: taken = (acc_q == '0);
        default:       taken = 1'b0;
      endcase
    end
  end
  assign pc_inc  = pc_q + ADDR_W'(1);
  assign pc_next = taken ? ad_q : pc_inc;

  // Sequencer: next state, store port and unit request
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = load_address_i;
    ram_wdata     = load_value_i;
    ram_raddr     = pc_q;
    md_req.start  = 1'b0;
    md_req.is_div = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_RESP;
          if (mode_i == MODE_LOAD) begin
            ram_we = (load_address_i <= LAST_ADDR);
          end else if (mode_i == MODE_EXEC) begin
            if (!stopped_q && pc_q <= LAST_ADDR) begin
              state_d = ST_FETCH;
            end
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_DECODE;
      end
      ST_DECODE: begin
        state_d = (rd_word == '0) ? ST_RESP : ST_ADDR;
      end
      ST_ADDR: begin
        ram_raddr = ad_full[ADDR_W-1:0];
        state_d   = ST_OPER;
      end
      ST_OPER: begin
        state_d   = ST_RESP;
        ram_waddr = ad_q;
        ram_wdata = (opc == OP_READ) ? read_value_q : acc_q;
        if (known_q) begin
          case (opc)
            OP_READ, OP_STORE: ram_we = 1'b1;
            OP_MUL: begin
              md_req.start = 1'b1;
              state_d      = ST_ITER;
            end
            OP_DIV: begin
              md_req.is_div = 1'b1;
              if (rd_word != '0) begin
                md_req.start = 1'b1;
                state_d      = ST_ITER;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_ITER: begin
        if (md_rsp.done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Per-word valid bits: an unwritten word reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_vld_q <= valid_q[ram_raddr];
  end

  // Architectural state: pc, accumulator, halt flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= '0;
      acc_q     <= '0;
      stopped_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (mode_i == MODE_RESTART) begin
              pc_q      <= '0;
              acc_q     <= '0;
              stopped_q <= 1'b0;
            end else if (mode_i == MODE_EXEC && !stopped_q && pc_q > LAST_ADDR) begin
              stopped_q <= 1'b1;
            end
          end
        end
        ST_DECODE: begin
          if (rd_word == '0) begin
            stopped_q <= 1'b1;
          end
        end
        ST_OPER: begin
          if (known_q && opc == OP_HALT) begin
            stopped_q <= 1'b1;
          end else begin
            pc_q <= pc_next;
            if (pc_next > LAST_ADDR) begin
              pc_q      <= END_ADDR;
              stopped_q <= 1'b1;
            end
          end
          if (known_q) begin
            case (opc)
              OP_LOAD: acc_q <= rd_word;
              OP_ADD:  acc_q <= acc_q + rd_word;
              OP_SUB:  acc_q <= acc_q - rd_word;
              default: acc_q <= acc_q;
            endcase
          end
        end
        ST_ITER: begin
          if (md_rsp.done) begin
            acc_q <= md_rsp.result;
          end
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

  // Step flags and captured payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q <= read_value_i;
      wv_q         <= 1'b0;
      wval_q       <= '0;
      ru_q         <= 1'b0;
      df_q         <= 1'b0;
    end
    if (state_q == ST_DECODE) begin
      op_q    <= recip_prod[RECIP_SHIFT +: OPC_W];
      dec_q   <= rd_word[DEC_W-1:0];
      known_q <= word_known;
    end
    if (state_q == ST_ADDR) begin
      ad_q <= ad_full[ADDR_W-1:0];
    end
    if (state_q == ST_OPER && known_q) begin
      case (opc)
        OP_READ:  ru_q <= 1'b1;
        OP_WRITE: begin
          wv_q   <= 1'b1;
          wval_q <= rd_word;
        end
        OP_DIV:   df_q <= (rd_word == '0);
        default:  ru_q <= ru_q;
      endcase
    end
  end

  // Output register: load when the slot is free, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == ST_RESP && out_free) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESP && out_free) begin
      write_valid_o     <= wv_q;
      write_value_o     <= wval_q;
      read_used_o       <= ru_q;
      halted_o          <= stopped_q;
      divide_fault_o    <= df_q;
      program_counter_o <= pc_q;
      accumulator_out_o <= acc_q;
    end
  end

  dam_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dam_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (acc_q),
    .b_i    (rd_word),
    .rsp_o  (md_rsp)
  );

endmodule

`default_nettype wire
